@@ hdl/frame_rate_window_monitor_assert.svh @@
// Assertion macros shared by the frame rate window monitor RTL.
`ifndef FRAME_RATE_WINDOW_MONITOR_ASSERT_SVH
`define FRAME_RATE_WINDOW_MONITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define FRWM_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("frwm same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define FRWM_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("frwm next-cycle check failed");

`endif

@@ hdl/frwm_pkg.sv @@
// Shared constants, types and the sequencer state for the frame rate window monitor.
`default_nettype none

package frwm_pkg;

	// Field widths of the channels.
	localparam int ELAPSED_W  = 16;
	localparam int INTERVAL_W = 16;
	localparam int FPS_W      = 18;
	localparam int COUNT_W    = 32;

	// Window length default and rate scaling.
	localparam int WINDOW_LENGTH_DEF = 32;
	localparam int RATE_SCALE        = 1000;
	localparam int Q8_SCALE          = 256;

	// Largest rate the divider can return: every stored time equal to one ms.
	localparam logic [FPS_W-1:0] MAX_FPS_Q8 = FPS_W'(RATE_SCALE * Q8_SCALE);

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_UPD,
		S_CHK,
		S_DIV
	} frwm_state_t;

	// Control from the sequencer to the window store.
	typedef struct packed {
		logic rd;
		logic upd;
	} win_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/frwm_in_if.sv @@
// Input channel: one beat per captured frame.
`default_nettype none

interface frwm_in_if import frwm_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, output elapsed_ms, input ready);
	modport sink (input valid, input elapsed_ms, output ready);
endinterface

`default_nettype wire

@@ hdl/frwm_out_if.sv @@
// Output channel: one beat per emitted statistics result.
`default_nettype none

interface frwm_out_if import frwm_pkg::*;;
	logic               valid;
	logic               ready;
	logic [FPS_W-1:0]   average_fps_q8;
	logic [COUNT_W-1:0] frame_count;

	modport source (output valid, output average_fps_q8, output frame_count, input ready);
	modport sink (input valid, input average_fps_q8, input frame_count, output ready);
endinterface

`default_nettype wire

@@ hdl/frwm_cfg_if.sv @@
// Configuration write channel carrying the emit interval.
`default_nettype none

interface frwm_cfg_if import frwm_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [INTERVAL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/frwm_window.sv @@
// Circular store of recent frame times with write pointer, fill level and running sum.
`default_nettype none

module frwm_window import frwm_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	localparam int PTR_W  = $clog2(WINDOW_LENGTH),
	localparam int FILL_W = $clog2(WINDOW_LENGTH + 1),
	localparam int SUM_W  = PTR_W + ELAPSED_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire win_ctrl_t            ctrl,
	input  wire logic [ELAPSED_W-1:0] elapsed_ms,
	output logic                      full,
	output logic [SUM_W-1:0]          sum
);

	logic [ELAPSED_W-1:0] mem_q [WINDOW_LENGTH];
	logic [ELAPSED_W-1:0] old_q;
	logic [PTR_W-1:0]     wptr_q;
	logic [FILL_W-1:0]    fill_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     sum_add;

	assign full = (fill_q == FILL_W'(WINDOW_LENGTH));
	assign sum  = sum_q;

	// The oldest time leaves the sum only once the window is full.
	assign sum_add = sum_q + SUM_W'(elapsed_ms);

	// Time store: registered read of the slot about to be replaced, then the write.
	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			old_q <= mem_q[wptr_q];
		end
		if (ctrl.upd) begin
			mem_q[wptr_q] <= elapsed_ms;
		end
	end

	// Pointer, fill level and running sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (ctrl.upd) begin
			if (wptr_q == PTR_W'(WINDOW_LENGTH - 1)) begin
				wptr_q <= '0;
			end else begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (full) begin
				sum_q <= sum_add - SUM_W'(old_q);
			end else begin
				sum_q  <= sum_add;
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/frwm_divider.sv @@
// Restoring divider: one shared subtract and compare step per cycle for the rate quotient.
`default_nettype none

module frwm_divider import frwm_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	localparam int SUM_W = $clog2(WINDOW_LENGTH) + ELAPSED_W,
	localparam int NUM_W = $clog2(RATE_SCALE * Q8_SCALE * WINDOW_LENGTH + 1),
	localparam int CNT_W = $clog2(FPS_W + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] divisor,
	output logic                  busy,
	output logic [FPS_W-1:0]      quotient
);

	// Dividend; the quotient is known to fit FPS_W bits, so only its low bits are walked.
	localparam logic [NUM_W-1:0] NUM = NUM_W'(RATE_SCALE * Q8_SCALE * WINDOW_LENGTH);

	logic [SUM_W-1:0] rem_q;
	logic [FPS_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [SUM_W:0]   shifted;
	logic [SUM_W+1:0] diff;
	logic             ge;

	assign busy     = busy_q;
	assign quotient = quo_q;

	// Shared step: shift in the next dividend bit and try to subtract the divisor.
	assign shifted = {rem_q, quo_q[FPS_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign ge      = !diff[SUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(FPS_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SUM_W'(NUM >> FPS_W);
			quo_q <= NUM[FPS_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
			quo_q <= {quo_q[FPS_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

@@ hdl/frame_rate_window_monitor.sv @@
// Top level of the frame rate window monitor: sequencer, counters and result register.
//
// Usage. frame takes one beat per captured frame with its elapsed time in ms.
// Every beat counts a frame. A beat with a nonzero time enters the sliding window
// of the last WINDOW_LENGTH times; once the window is full, every such beat
// advances a decimation counter, and each emit_interval-th one gives one beat on
// stats: floor(256000*WINDOW_LENGTH/sum) in Q8 frames per second and the
// frame count. cfg writes emit_interval (reset value 1) and is always ready.
// Sequence. A zero-time beat leaves frame.ready high. A nonzero beat keeps frame.ready
// low through the window update and then the check. A beat that emits runs the
// serial divider, one quotient bit per cycle; its result is loaded into the
// output register once the divider is done and that register is free, and
// only then is the next beat taken.
// Stalls. The result sits in an output register, so new frames are accepted while
// it waits; a later division that finishes before it is taken holds until then.
// Reset. arst_n clears counters, pointer, fill level and sum; the window is empty.
`default_nettype none

module frame_rate_window_monitor import frwm_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	frwm_in_if.sink     frame,
	frwm_out_if.source  stats,
	frwm_cfg_if.sink    cfg
);

`include "frame_rate_window_monitor_assert.svh"

	localparam int SUM_W = $clog2(WINDOW_LENGTH) + ELAPSED_W;

	frwm_state_t           state_q, state_d;
	win_ctrl_t             win_ctrl;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [INTERVAL_W-1:0] emit_interval_q;
	logic [INTERVAL_W-1:0] emit_counter_q;
	logic [INTERVAL_W:0]   emit_next;
	logic                  emit;
	logic [COUNT_W-1:0]    frames_seen_q;
	logic                  accept;
	logic                  win_full;
	logic [SUM_W-1:0]      win_sum;
	logic                  div_start;
	logic                  div_busy;
	logic [FPS_W-1:0]      div_quotient;
	logic                  out_free;
	logic                  load_out;
	logic                  out_valid_q;
	logic [FPS_W-1:0]      fps_q;
	logic [COUNT_W-1:0]    count_q;

	assign accept    = frame.valid && frame.ready;
	assign out_free  = !out_valid_q || stats.ready;
	assign cfg.ready = 1'b1;

	// Decimation: an interval of zero behaves like one.
	assign emit_next = {1'b0, emit_counter_q} + 1'b1;
	assign emit      = !(emit_next < {1'b0, emit_interval_q});

	frwm_window #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (win_ctrl),
		.elapsed_ms (elapsed_q),
		.full       (win_full),
		.sum        (win_sum)
	);

	frwm_divider #(
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (win_sum),
		.busy     (div_busy),
		.quotient (div_quotient)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control outputs.
	always_comb begin
		state_d     = state_q;
		frame.ready = 1'b0;
		win_ctrl    = '0;
		div_start   = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			S_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid && (frame.elapsed_ms != '0)) begin
					win_ctrl.rd = 1'b1;
					state_d     = S_UPD;
				end
			end
			S_UPD: begin
				win_ctrl.upd = 1'b1;
				state_d      = S_CHK;
			end
			S_CHK: begin
				if (win_full && emit) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (!div_busy && out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Frame counter, decimation counter and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_seen_q   <= '0;
			emit_counter_q  <= '0;
			emit_interval_q <= INTERVAL_W'(1);
		end else begin
			if (accept) begin
				frames_seen_q <= frames_seen_q + 1'b1;
			end
			if ((state_q == S_CHK) && win_full) begin
				emit_counter_q <= emit ? '0 : emit_next[INTERVAL_W-1:0];
			end
			if (cfg.valid && cfg.ready) begin
				emit_interval_q <= cfg.data;
			end
		end
	end

	// Captured frame time for the window update.
	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_q <= frame.elapsed_ms;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (stats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; an empty sum cannot occur while full but answers zero.
	always_ff @(posedge clk) begin
		if (load_out) begin
			fps_q   <= (win_sum == '0) ? '0 : div_quotient;
			count_q <= frames_seen_q;
		end
	end

	assign stats.valid          = out_valid_q;
	assign stats.average_fps_q8 = fps_q;
	assign stats.frame_count    = count_q;

	// A nonzero frame always goes on to the window update.
	`FRWM_ASSERT_NXT(a_nonzero_updates, accept && (frame.elapsed_ms != '0), state_q == S_UPD)
	// Division only runs on a full window.
	`FRWM_ASSERT_IMP(a_div_needs_full, state_q == S_DIV, win_full)
	// An emitted rate never exceeds the one-millisecond bound.
	`FRWM_ASSERT_IMP(a_fps_bound, out_valid_q, fps_q <= MAX_FPS_Q8)
	// A loaded result is presented in the next cycle.
	`FRWM_ASSERT_NXT(a_load_shows, load_out, out_valid_q)

endmodule

`default_nettype wire

@@ tb/tb_frame_rate_window_monitor.sv @@
// Self-checking testbench for the frame rate window monitor: drives frames, predicts stats beats.
`timescale 1ns / 1ps

module tb_frame_rate_window_monitor;
	import frwm_pkg::*;

	localparam int CLK_HIGH_NS  = 6;
	localparam int CLK_LOW_NS   = 6;
	localparam int RESET_CYCLES = 9;
	localparam int WIN_LEN      = WINDOW_LENGTH_DEF;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS  = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam longint unsigned RATE_NUM = longint'(RATE_SCALE) * WIN_LEN * Q8_SCALE;

	// Kinds of frame-time runs used by the random stimulus.
	typedef enum int {
		RUN_ANY,
		RUN_ONES,
		RUN_MAX,
		RUN_TYPICAL,
		RUN_ZERO
	} run_kind_t;

	typedef struct packed {
		logic [FPS_W-1:0]   fps_q8;
		logic [COUNT_W-1:0] count;
	} stats_t;

	// Tracks the window and decimation state and holds the stats beats still owed.
	class frame_rate_checker;
		bit [ELAPSED_W-1:0]  win_ms [WIN_LEN];
		int unsigned         win_ptr;
		int unsigned         win_fill;
		int unsigned         win_total;
		int unsigned         decim_cnt;
		bit [COUNT_W-1:0]    frames;
		bit [INTERVAL_W-1:0] emit_every;
		stats_t              expected_stats [$];
		int unsigned         mismatches;
		int unsigned         failures;

		function new();
			win_ptr    = 0;
			win_fill   = 0;
			win_total  = 0;
			decim_cnt  = 0;
			frames     = '0;
			emit_every = 1;
			mismatches = 0;
			failures   = 0;
		endfunction

		function void set_interval(bit [INTERVAL_W-1:0] v);
			emit_every = v;
		endfunction

		// Updates the window for one accepted frame and queues a stats beat when one is due.
		function void note_frame(bit [ELAPSED_W-1:0] ms);
			int unsigned next_cnt;
			stats_t      s;
			frames = frames + 1'b1;
			if (ms == 0) begin
				return;
			end
			if (win_fill == WIN_LEN) begin
				win_total -= win_ms[win_ptr];
			end else begin
				win_fill++;
			end
			win_total += ms;
			win_ms[win_ptr] = ms;
			win_ptr = (win_ptr + 1) % WIN_LEN;
			if (win_fill < WIN_LEN) begin
				return;
			end
			// An interval of zero behaves like one, since the count is always at least one.
			next_cnt = decim_cnt + 1;
			if (next_cnt < emit_every) begin
				decim_cnt = next_cnt;
				return;
			end
			decim_cnt = 0;
			s.fps_q8 = (win_total == 0) ? '0 : FPS_W'(RATE_NUM / win_total);
			s.count  = frames;
			expected_stats.push_back(s);
		endfunction

		// Compares one stats beat with the oldest one owed.
		function void check_stats(logic [FPS_W-1:0] fps, logic [COUNT_W-1:0] cnt);
			stats_t want;
			if (expected_stats.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected stats beat: fps_q8=%0d frame_count=%0d", fps, cnt);
				end
				return;
			end
			want = expected_stats.pop_front();
			if (fps !== want.fps_q8 || cnt !== want.count) begin
				failures++;
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display({"stats mismatch: expected fps_q8=%0d frame_count=%0d,",
						" got fps_q8=%0d frame_count=%0d"},
						want.fps_q8, want.count, fps, cnt);
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_stats.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;

	int gap_pct   = 0;
	int stall_pct = 0;
	int hold_left = 0;

	frame_rate_checker sb = new();

	frwm_in_if  frame_if ();
	frwm_out_if stats_if ();
	frwm_cfg_if cfg_if ();

	frame_rate_window_monitor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.stats  (stats_if),
		.cfg    (cfg_if)
	);

	// Free-running clock.
	always begin
		clk = 1'b1;
		#CLK_HIGH_NS;
		clk = 1'b0;
		#CLK_LOW_NS;
	end

	// Receiver: random stalls, or a long hold-off while hold_left runs down.
	initial begin
		stats_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				stats_if.ready = 1'b0;
				hold_left--;
			end else begin
				stats_if.ready = ($urandom_range(99, 0) >= stall_pct);
			end
		end
	end

	// Every stats beat taken is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && stats_if.valid === 1'b1 && stats_if.ready === 1'b1) begin
			sb.check_stats(stats_if.average_fps_q8, stats_if.frame_count);
		end
	end

	// Run guard.
	initial begin
		#(longint'(LIMIT_CYCLES) * (CLK_HIGH_NS + CLK_LOW_NS));
		$display("timeout with %0d stats beats outstanding", sb.outstanding());
		$display("status: fail");
		$finish;
	end

	// Offers one frame after a random gap and waits for its beat to be taken.
	task automatic send_frame(input logic [ELAPSED_W-1:0] ms);
		while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
			@(negedge clk);
			frame_if.valid = 1'b0;
		end
		@(negedge clk);
		frame_if.valid      = 1'b1;
		frame_if.elapsed_ms = ms;
		do @(posedge clk); while (frame_if.ready !== 1'b1);
		sb.note_frame(ms);
	endtask

	task automatic stop_frames();
		@(negedge clk);
		frame_if.valid = 1'b0;
	endtask

	task automatic wait_stats_drained();
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	// Writes the emit interval once the block is idle and every owed beat has arrived.
	task automatic write_interval(input logic [INTERVAL_W-1:0] v);
		stop_frames();
		wait_stats_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.data  = v;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		sb.set_interval(v);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	function automatic logic [ELAPSED_W-1:0] draw_ms(input run_kind_t kind);
		case (kind)
			RUN_ONES:    return 16'd1;
			RUN_MAX:     return '1;
			RUN_TYPICAL: return ELAPSED_W'($urandom_range(50, 1));
			RUN_ZERO:    return '0;
			default:     return ELAPSED_W'($urandom);
		endcase
	endfunction

	// Sends runs of frame times until n nonzero frames have gone in; zero frames are extra.
	task automatic random_frames(input int n);
		run_kind_t            kind;
		int                   pick;
		int                   run_len;
		logic [ELAPSED_W-1:0] ms;
		while (n > 0) begin
			pick = $urandom_range(99, 0);
			if (pick < 40) begin
				kind = RUN_ANY;
			end else if (pick < 46) begin
				kind = RUN_ONES;
			end else if (pick < 52) begin
				kind = RUN_MAX;
			end else if (pick < 92) begin
				kind = RUN_TYPICAL;
			end else begin
				kind = RUN_ZERO;
			end
			// Constant runs cover a whole window so the extreme rates come out.
			if (kind == RUN_ONES || kind == RUN_MAX) begin
				run_len = $urandom_range(WIN_LEN + 8, WIN_LEN);
			end else if (kind == RUN_ZERO) begin
				run_len = $urandom_range(3, 1);
			end else begin
				run_len = $urandom_range(12, 1);
			end
			for (int i = 0; i < run_len && n > 0; i++) begin
				ms = draw_ms(kind);
				send_frame(ms);
				if (ms != 0) begin
					n--;
				end
			end
		end
	endtask

	// Main sequence.
	initial begin
		logic [ELAPSED_W-1:0] directed [$];
		frame_if.valid      = 1'b0;
		frame_if.elapsed_ms = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.data         = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at the reset interval: zero times, field extremes, bit patterns.
		directed = '{16'd0, 16'd0, 16'd1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555,
			16'hAAAA, 16'd0, 16'd1, 16'hFFFE, 16'd2, 16'd1000, 16'd33};
		foreach (directed[i]) begin
			send_frame(directed[i]);
		end
		random_frames(120);

		// Interval zero acts like one; sender idles often.
		write_interval(16'd0);
		gap_pct = 88;
		random_frames(80);

		// Decimation by three; receiver stalls often.
		write_interval(16'd3);
		gap_pct   = 0;
		stall_pct = 88;
		random_frames(100);

		// Largest interval, then lowered below the running count.
		write_interval('1);
		gap_pct   = 19;
		stall_pct = 19;
		random_frames(50);
		write_interval(16'd2);
		random_frames(60);

		// Long receiver hold-off with frames offered back to back, then a full drain.
		write_interval(16'd1);
		gap_pct   = 0;
		stall_pct = 0;
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		random_frames(60);
		stop_frames();
		wait_stats_drained();
		random_frames(60);

		write_interval(16'd7);
		gap_pct   = 19;
		stall_pct = 19;
		random_frames(80);

		// Let everything settle, then judge.
		stop_frames();
		wait_stats_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$display("%0d expected stats beats never arrived", sb.outstanding());
			sb.failures += sb.outstanding();
		end
		if (sb.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
